FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL; they sample on clk and hold off during arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_IMPLIES(lbl, pre, post)
`endif
`endif

FILE: rtl/core/ntt_pkg.sv
package ntt_pkg;

	localparam int COEF_W = 31;
	localparam int STEP_W = $clog2(COEF_W);
	localparam int MAX_COEFFS_DEF = 1024;
	// must be a power of two
	localparam int MAX_LENGTH_DEF = 2048;
	localparam logic [COEF_W-1:0] MOD_RESET = 31'd998244353;

	// a + b mod m, both operands below m
	function automatic logic [COEF_W-1:0] add_mod(input logic [COEF_W-1:0] a,
		input logic [COEF_W-1:0] b, input logic [COEF_W-1:0] m);
		logic [COEF_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m}) s = s - {1'b0, m};
		return s[COEF_W-1:0];
	endfunction

endpackage

FILE: rtl/core/ntt_ram.sv
module ntt_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/ntt_modmul.sv
// Interleaved modular multiplier: one bit of x per cycle, MSB first.
module ntt_modmul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ntt_pkg::COEF_W-1:0]  x,
	input  logic [ntt_pkg::COEF_W-1:0]  y,
	input  logic [ntt_pkg::COEF_W-1:0]  p,
	output logic                        busy,
	output logic                        done,
	output logic [ntt_pkg::COEF_W-1:0]  res
);

	logic [ntt_pkg::COEF_W-1:0] x_q, y_q, r_q, r_dbl, r_n;
	logic [ntt_pkg::STEP_W-1:0] cnt_q;
	logic busy_q, done_q;

	always_comb begin
		r_dbl = ntt_pkg::add_mod(r_q, r_q, p);
		r_n = x_q[cnt_q] ? ntt_pkg::add_mod(r_dbl, y_q, p) : r_dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			r_q <= '0;
			x_q <= '0;
			y_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q <= x;
				y_q <= y;
				r_q <= '0;
				cnt_q <= ntt_pkg::STEP_W'(ntt_pkg::COEF_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				r_q <= r_n;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign res = r_q;

endmodule

FILE: rtl/core/ntt_polynomial_multiplier_unit.sv
// Load request: a new request may follow at once. The last load starts the product
// and holds busy until it is done, doing all modular multiplies in the shared bit-serial
// multiplier: 3*(L/2)*log2(L) butterflies of up to two multiplies, 2n+2L reduce, pointwise
// and scale multiplies, and one or two powers of up to 31 bits per stage (L = transform length).
// Drain request: busy for 1 cycle, then done shows with the coefficient; a new one waits for idle.
// Reset: loading phase, no coefficients held, modulus 998244353; stores hold garbage.
`include "assert_macros.svh"
module ntt_polynomial_multiplier_unit #(
	parameter int MAX_COEFFS = ntt_pkg::MAX_COEFFS_DEF,
	parameter int MAX_LENGTH = ntt_pkg::MAX_LENGTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       cmd,
	input  logic [ntt_pkg::COEF_W-1:0] a_coeff,
	input  logic [ntt_pkg::COEF_W-1:0] b_coeff,
	input  logic                       last,
	input  logic                       modulus_we,
	input  logic [ntt_pkg::COEF_W-1:0] modulus,
	output logic                       done,
	output logic [ntt_pkg::COEF_W-1:0] product_coeff,
	output logic                       last_out
);

	localparam int CW_ = ntt_pkg::COEF_W;
	localparam int AW = $clog2(MAX_LENGTH);
	localparam int IW = AW + 1;
	localparam int LW = $clog2(AW + 1);
	localparam int SW = $clog2(AW + 2);
	localparam int NW = $clog2(MAX_COEFFS + 1);
	localparam int DW = $clog2(2 * MAX_COEFFS);
	localparam int TW = DW + 1;
	localparam int LIMIT = (MAX_COEFFS < MAX_LENGTH) ? MAX_COEFFS : MAX_LENGTH;

	typedef enum logic [5:0] {
		S_IDLE, S_DRAIN, S_PREP, S_PAD, S_ZERO, S_FIN,
		S_RED_RD, S_RED_A, S_RED_AW, S_RED_BW,
		S_BR, S_BR_R1, S_BR_R2, S_BR_W,
		S_ST, S_ST_W1, S_ST_W2,
		S_BF_RD, S_BF_MUL, S_BF_U, S_BF_WAIT, S_BF_W2, S_BF_WW,
		S_SC_SET, S_SC_RD, S_SC_MUL, S_SC_WAIT, S_TF_DONE,
		S_PW_RD, S_PW_MUL, S_PW_WAIT,
		S_POW_INIT, S_POW_RED, S_POW_LOOP, S_POW_R, S_POW_B
	} state_t;

	typedef enum logic { PH_LOAD, PH_DRAIN } phase_t;
	typedef enum logic [1:0] { PASS_FWD_A, PASS_FWD_B, PASS_INV } pass_t;

	state_t state_q, ret_q;
	phase_t phase_q;
	pass_t pass_q;
	logic [CW_-1:0] mod_q, u_q, t_q, w_q, wn_q, pb_q, pe_q, pr_q;
	logic [CW_-1:0] product_q;
	logic lo_q, done_q, oob_q;
	logic [NW-1:0] n_q, n_eff, n_next;
	logic [DW-1:0] dcnt_q;
	logic [TW-1:0] total, dcnt_inc;
	logic [LW-1:0] lg_q, lg_c;
	logic [SW-1:0] stage_q;
	logic [IW-1:0] i_q, len;
	logic [AW-1:0] k_q, lowmask, idx0, idx1, rev_full, rev;
	logic jz, jlast, accept, is_inv, sel_b;

	logic we_a, we_b;
	logic [AW-1:0] waddr, raddr;
	logic [CW_-1:0] wd_a, wd_b, rd_a, rd_b, rd_sel, wdat;

	logic mm_start, mm_busy, mm_done;
	logic [CW_-1:0] mm_x, mm_y, mm_res;

	ntt_ram #(.WIDTH(CW_), .DEPTH(MAX_LENGTH)) u_ram_a (
		.clk(clk), .we(we_a), .waddr(waddr), .wdata(wd_a), .raddr(raddr), .rdata(rd_a)
	);
	ntt_ram #(.WIDTH(CW_), .DEPTH(MAX_LENGTH)) u_ram_b (
		.clk(clk), .we(we_b), .waddr(waddr), .wdata(wd_b), .raddr(raddr), .rdata(rd_b)
	);
	ntt_modmul u_mm (
		.clk(clk), .arst_n(arst_n), .start(mm_start), .x(mm_x), .y(mm_y), .p(mod_q),
		.busy(mm_busy), .done(mm_done), .res(mm_res)
	);

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign is_inv = (pass_q == PASS_INV);
	assign sel_b = (pass_q == PASS_FWD_B);
	assign rd_sel = sel_b ? rd_b : rd_a;
	assign n_eff = (phase_q == PH_DRAIN) ? '0 : n_q;
	assign n_next = (n_eff < NW'(LIMIT)) ? n_eff + 1'b1 : n_eff;
	assign total = (TW'(n_q) << 1) - TW'(1);
	assign dcnt_inc = TW'(dcnt_q) + TW'(1);
	assign len = IW'(1) << lg_q;
	assign lowmask = (AW'(1) << (stage_q - SW'(1))) - AW'(1);
	assign idx0 = ((k_q & ~lowmask) << 1) | (k_q & lowmask);
	assign idx1 = idx0 | (lowmask + AW'(1));
	assign jz = (k_q & lowmask) == '0;
	assign jlast = (k_q & lowmask) == lowmask;

	// least power of two at least 2n, capped at the store size
	always_comb begin
		lg_c = LW'(AW);
		for (int k = AW - 1; k >= 1; k--) begin
			if ((32'd1 << k) >= (32'(n_q) << 1)) lg_c = LW'(k);
		end
	end

	always_comb begin
		rev_full = '0;
		for (int b = 0; b < AW; b++) rev_full[AW-1-b] = i_q[b];
		rev = rev_full >> (AW - 32'(lg_q));
	end

	// memory and multiplier requests per state
	always_comb begin
		we_a = 1'b0;
		we_b = 1'b0;
		waddr = AW'(i_q);
		raddr = AW'(i_q);
		wdat = '0;
		wd_a = '0;
		wd_b = '0;
		mm_start = 1'b0;
		mm_x = '0;
		mm_y = '0;
		unique case (state_q)
			S_IDLE: begin
				raddr = AW'(dcnt_q);
				waddr = AW'(n_eff);
				wd_a = a_coeff;
				wd_b = b_coeff;
				if (accept && !cmd && n_eff < NW'(LIMIT)) begin
					we_a = 1'b1;
					we_b = 1'b1;
				end
			end
			S_PAD: begin
				we_a = (i_q < len);
				we_b = (i_q < len);
			end
			S_ZERO: we_a = (i_q < len);
			S_RED_A: begin
				mm_start = 1'b1;
				mm_x = rd_a;
				mm_y = CW_'(1);
			end
			S_RED_AW: begin
				wd_a = mm_res;
				we_a = mm_done;
				mm_start = mm_done;
				mm_x = t_q;
				mm_y = CW_'(1);
			end
			S_RED_BW: begin
				wd_b = mm_res;
				we_b = mm_done;
			end
			S_BR_R1: raddr = rev;
			S_BR_R2: begin
				wdat = rd_sel;
				we_a = !sel_b;
				we_b = sel_b;
			end
			S_BR_W: begin
				waddr = rev;
				wdat = u_q;
				we_a = !sel_b;
				we_b = sel_b;
			end
			S_BF_RD: raddr = idx1;
			S_BF_MUL: begin
				raddr = idx0;
				mm_start = 1'b1;
				mm_x = rd_sel;
				mm_y = w_q;
			end
			S_BF_WAIT: begin
				waddr = idx0;
				wdat = ntt_pkg::add_mod(u_q, mm_res, mod_q);
				we_a = mm_done && !sel_b;
				we_b = mm_done && sel_b;
			end
			S_BF_W2: begin
				waddr = idx1;
				wdat = ntt_pkg::add_mod(u_q, mod_q - t_q, mod_q);
				we_a = !sel_b;
				we_b = sel_b;
				mm_start = !jlast;
				mm_x = w_q;
				mm_y = wn_q;
			end
			S_SC_MUL: begin
				mm_start = 1'b1;
				mm_x = rd_sel;
				mm_y = wn_q;
			end
			S_SC_WAIT: begin
				wdat = mm_res;
				we_a = mm_done && !sel_b;
				we_b = mm_done && sel_b;
			end
			S_PW_MUL: begin
				mm_start = 1'b1;
				mm_x = rd_a;
				mm_y = rd_b;
			end
			S_PW_WAIT: begin
				wd_a = mm_res;
				we_a = mm_done;
			end
			S_POW_INIT: begin
				mm_start = 1'b1;
				mm_x = pb_q;
				mm_y = CW_'(1);
			end
			S_POW_LOOP: begin
				mm_start = (pe_q != '0);
				mm_x = pe_q[0] ? pr_q : pb_q;
				mm_y = pb_q;
			end
			S_POW_R: begin
				mm_start = mm_done;
				mm_x = pb_q;
				mm_y = pb_q;
			end
			default: ;
		endcase
		// transform passes write one array through the shared data word
		if (state_q == S_BR_R2 || state_q == S_BR_W || state_q == S_BF_WAIT ||
			state_q == S_BF_W2 || state_q == S_SC_WAIT) begin
			wd_a = wdat;
			wd_b = wdat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			phase_q <= PH_LOAD;
			pass_q <= PASS_FWD_A;
			mod_q <= ntt_pkg::MOD_RESET;
			n_q <= '0;
			dcnt_q <= '0;
			done_q <= 1'b0;
			lo_q <= 1'b0;
			oob_q <= 1'b0;
			product_q <= '0;
			lg_q <= '0;
			stage_q <= '0;
			i_q <= '0;
			k_q <= '0;
			u_q <= '0;
			t_q <= '0;
			w_q <= '0;
			wn_q <= '0;
			pb_q <= '0;
			pe_q <= '0;
			pr_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (modulus_we) mod_q <= modulus;
			unique case (state_q)
				S_IDLE: begin
					if (accept && !cmd) begin
						if (phase_q == PH_DRAIN) begin
							phase_q <= PH_LOAD;
							dcnt_q <= '0;
						end
						n_q <= n_next;
						if (last || n_next >= NW'(LIMIT)) state_q <= S_PREP;
					end else if (accept && phase_q == PH_DRAIN) begin
						oob_q <= (32'(dcnt_q) >= 32'(MAX_LENGTH));
						lo_q <= (dcnt_inc == total);
						if (dcnt_inc >= total) begin
							phase_q <= PH_LOAD;
							n_q <= '0;
							dcnt_q <= '0;
						end else begin
							dcnt_q <= dcnt_q + 1'b1;
						end
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					done_q <= 1'b1;
					product_q <= oob_q ? '0 : rd_a;
					state_q <= S_IDLE;
				end
				S_PREP: begin
					lg_q <= lg_c;
					i_q <= IW'(n_q);
					state_q <= S_PAD;
				end
				S_PAD: begin
					if (i_q < len) begin
						i_q <= i_q + 1'b1;
					end else begin
						i_q <= '0;
						state_q <= (mod_q < CW_'(2)) ? S_ZERO : S_RED_RD;
					end
				end
				S_ZERO: begin
					if (i_q < len) i_q <= i_q + 1'b1;
					else state_q <= S_FIN;
				end
				S_FIN: begin
					phase_q <= PH_DRAIN;
					dcnt_q <= '0;
					state_q <= S_IDLE;
				end
				S_RED_RD: begin
					if (i_q < IW'(n_q)) begin
						state_q <= S_RED_A;
					end else begin
						pass_q <= PASS_FWD_A;
						i_q <= '0;
						state_q <= S_BR;
					end
				end
				S_RED_A: begin
					t_q <= rd_b;
					state_q <= S_RED_AW;
				end
				S_RED_AW: if (mm_done) state_q <= S_RED_BW;
				S_RED_BW: begin
					if (mm_done) begin
						i_q <= i_q + 1'b1;
						state_q <= S_RED_RD;
					end
				end
				S_BR: begin
					if (i_q < len) begin
						if (IW'(rev) > i_q) state_q <= S_BR_R1;
						else i_q <= i_q + 1'b1;
					end else begin
						stage_q <= SW'(1);
						state_q <= S_ST;
					end
				end
				S_BR_R1: begin
					u_q <= rd_sel;
					state_q <= S_BR_R2;
				end
				S_BR_R2: state_q <= S_BR_W;
				S_BR_W: begin
					i_q <= i_q + 1'b1;
					state_q <= S_BR;
				end
				S_ST: begin
					if (stage_q <= SW'(lg_q)) begin
						pb_q <= CW_'(3);
						pe_q <= (mod_q - CW_'(1)) >> stage_q;
						ret_q <= S_ST_W1;
						state_q <= S_POW_INIT;
					end else if (is_inv) begin
						pb_q <= CW_'(len);
						pe_q <= mod_q - CW_'(2);
						ret_q <= S_SC_SET;
						state_q <= S_POW_INIT;
					end else begin
						state_q <= S_TF_DONE;
					end
				end
				S_ST_W1: begin
					wn_q <= pr_q;
					if (is_inv) begin
						pb_q <= pr_q;
						pe_q <= mod_q - CW_'(2);
						ret_q <= S_ST_W2;
						state_q <= S_POW_INIT;
					end else begin
						k_q <= '0;
						state_q <= S_BF_RD;
					end
				end
				S_ST_W2: begin
					wn_q <= pr_q;
					k_q <= '0;
					state_q <= S_BF_RD;
				end
				S_BF_RD: begin
					if ({1'b0, k_q} < (len >> 1)) begin
						if (jz) w_q <= CW_'(1);
						state_q <= S_BF_MUL;
					end else begin
						stage_q <= stage_q + 1'b1;
						state_q <= S_ST;
					end
				end
				S_BF_MUL: state_q <= S_BF_U;
				S_BF_U: begin
					u_q <= rd_sel;
					state_q <= S_BF_WAIT;
				end
				S_BF_WAIT: begin
					if (mm_done) begin
						t_q <= mm_res;
						state_q <= S_BF_W2;
					end
				end
				S_BF_W2: begin
					if (jlast) begin
						k_q <= k_q + 1'b1;
						state_q <= S_BF_RD;
					end else begin
						state_q <= S_BF_WW;
					end
				end
				S_BF_WW: begin
					if (mm_done) begin
						w_q <= mm_res;
						k_q <= k_q + 1'b1;
						state_q <= S_BF_RD;
					end
				end
				S_SC_SET: begin
					wn_q <= pr_q;
					i_q <= '0;
					state_q <= S_SC_RD;
				end
				S_SC_RD: state_q <= (i_q < len) ? S_SC_MUL : S_TF_DONE;
				S_SC_MUL: state_q <= S_SC_WAIT;
				S_SC_WAIT: begin
					if (mm_done) begin
						i_q <= i_q + 1'b1;
						state_q <= S_SC_RD;
					end
				end
				S_TF_DONE: begin
					i_q <= '0;
					unique case (pass_q)
						PASS_FWD_A: begin
							pass_q <= PASS_FWD_B;
							state_q <= S_BR;
						end
						PASS_FWD_B: state_q <= S_PW_RD;
						default: state_q <= S_FIN;
					endcase
				end
				S_PW_RD: begin
					if (i_q < len) begin
						state_q <= S_PW_MUL;
					end else begin
						pass_q <= PASS_INV;
						i_q <= '0;
						state_q <= S_BR;
					end
				end
				S_PW_MUL: state_q <= S_PW_WAIT;
				S_PW_WAIT: begin
					if (mm_done) begin
						i_q <= i_q + 1'b1;
						state_q <= S_PW_RD;
					end
				end
				S_POW_INIT: state_q <= S_POW_RED;
				S_POW_RED: begin
					if (mm_done) begin
						pb_q <= mm_res;
						pr_q <= CW_'(1);
						state_q <= S_POW_LOOP;
					end
				end
				S_POW_LOOP: begin
					if (pe_q == '0) state_q <= ret_q;
					else state_q <= pe_q[0] ? S_POW_R : S_POW_B;
				end
				S_POW_R: begin
					if (mm_done) begin
						pr_q <= mm_res;
						state_q <= S_POW_B;
					end
				end
				S_POW_B: begin
					if (mm_done) begin
						pb_q <= mm_res;
						pe_q <= pe_q >> 1;
						state_q <= S_POW_LOOP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign product_coeff = product_q;
	assign last_out = lo_q;

	`ASSERT_IMPLIES(a_done_after_drain, done, $past(state_q == S_DRAIN))
	`ASSERT_IMPLIES(a_mm_no_overlap, mm_start, !mm_busy)
	`ASSERT_IMPLIES(a_mm_done_waited, mm_done, state_q == S_RED_AW || state_q == S_RED_BW || state_q == S_BF_WAIT || state_q == S_BF_WW || state_q == S_SC_WAIT || state_q == S_PW_WAIT || state_q == S_POW_RED || state_q == S_POW_R || state_q == S_POW_B)

endmodule
